// ===== design/assert_macros.svh =====
// Assertion helpers shared by the conversion pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define RMQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define RMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rmq_pkg.sv =====
package rmq_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

   // Branch picked by the largest diagonal element.
   typedef enum logic [2:0] {
      SEL_X = 3'b001,
      SEL_Y = 3'b010,
      SEL_Z = 3'b100
   } sel_type;

endpackage

// ===== design/rmq_if.sv =====
interface rmq_req_if #(parameter int W = 16);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] r00;
   logic signed [W-1:0] r10;
   logic signed [W-1:0] r20;
   logic signed [W-1:0] r01;
   logic signed [W-1:0] r11;
   logic signed [W-1:0] r21;
   logic signed [W-1:0] r02;
   logic signed [W-1:0] r12;
   logic signed [W-1:0] r22;

   modport source(output valid, r00, r10, r20, r01, r11, r21, r02, r12, r22, input ready);
   modport sink(input valid, r00, r10, r20, r01, r11, r21, r02, r12, r22, output ready);
endinterface

interface rmq_rsp_if #(parameter int W = 16);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] quat_x;
   logic signed [W-1:0] quat_y;
   logic signed [W-1:0] quat_z;
   logic signed [W-1:0] quat_w;
   logic                degenerate;

   modport source(output valid, quat_x, quat_y, quat_z, quat_w, degenerate, input ready);
   modport sink(input valid, quat_x, quat_y, quat_z, quat_w, degenerate, output ready);
endinterface

// ===== design/rmq_front.sv =====
module rmq_front #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [DATA_WIDTH-1:0]       r00,
   input  logic signed [DATA_WIDTH-1:0]       r10,
   input  logic signed [DATA_WIDTH-1:0]       r20,
   input  logic signed [DATA_WIDTH-1:0]       r01,
   input  logic signed [DATA_WIDTH-1:0]       r11,
   input  logic signed [DATA_WIDTH-1:0]       r21,
   input  logic signed [DATA_WIDTH-1:0]       r02,
   input  logic signed [DATA_WIDTH-1:0]       r12,
   input  logic signed [DATA_WIDTH-1:0]       r22,
   output logic                               out_valid,
   output rmq_pkg::sel_type                   sel,
   output logic [DATA_WIDTH+FRAC_BITS+1:0]    x,
   output logic signed [DATA_WIDTH:0]         n0,
   output logic signed [DATA_WIDTH:0]         n1,
   output logic signed [DATA_WIDTH:0]         n2
);
   import rmq_pkg::*;

   localparam int AW = DATA_WIDTH + 3;
   localparam int XW = DATA_WIDTH + FRAC_BITS + 2;
   localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

   logic signed [AW-1:0]         d00, d11, d22, arg;
   logic signed [DATA_WIDTH:0]   n0_in, n1_in, n2_in;
   logic [XW-1:0]                x_in;
   sel_type                      sel_in;
   logic                         valid_ff;
   sel_type                      sel_ff;
   logic [XW-1:0]                x_ff;
   logic signed [DATA_WIDTH:0]   n0_ff, n1_ff, n2_ff;

   assign d00 = AW'(r00);
   assign d11 = AW'(r11);
   assign d22 = AW'(r22);

   always_comb begin
      if (r00 > r11 && r00 > r22) begin
         sel_in = SEL_X;
         arg    = ONE + d00 - d11 - d22;
         n0_in  = {r01[DATA_WIDTH-1], r01} + {r10[DATA_WIDTH-1], r10};
         n1_in  = {r02[DATA_WIDTH-1], r02} + {r20[DATA_WIDTH-1], r20};
         n2_in  = {r21[DATA_WIDTH-1], r21} - {r12[DATA_WIDTH-1], r12};
      end else if (r11 > r22) begin
         sel_in = SEL_Y;
         arg    = ONE + d11 - d00 - d22;
         n0_in  = {r01[DATA_WIDTH-1], r01} + {r10[DATA_WIDTH-1], r10};
         n1_in  = {r12[DATA_WIDTH-1], r12} + {r21[DATA_WIDTH-1], r21};
         n2_in  = {r02[DATA_WIDTH-1], r02} - {r20[DATA_WIDTH-1], r20};
      end else begin
         sel_in = SEL_Z;
         arg    = ONE + d22 - d00 - d11;
         n0_in  = {r02[DATA_WIDTH-1], r02} + {r20[DATA_WIDTH-1], r20};
         n1_in  = {r12[DATA_WIDTH-1], r12} + {r21[DATA_WIDTH-1], r21};
         n2_in  = {r10[DATA_WIDTH-1], r10} - {r01[DATA_WIDTH-1], r01};
      end
      // radicand is arg scaled by 2^F, zero when arg is not positive
      if (arg > 0) begin
         x_in = {arg[AW-2:0], {FRAC_BITS{1'b0}}};
      end else begin
         x_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sel_ff <= sel_in;
         x_ff   <= x_in;
         n0_ff  <= n0_in;
         n1_ff  <= n1_in;
         n2_ff  <= n2_in;
      end
   end

   assign out_valid = valid_ff;
   assign sel       = sel_ff;
   assign x         = x_ff;
   assign n0        = n0_ff;
   assign n1        = n1_ff;
   assign n2        = n2_ff;

endmodule

// ===== design/rmq_sqrt.sv =====
module rmq_sqrt #(
   parameter int XW = 32,
   parameter int SW = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [XW-1:0]          x,
   input  logic [SW-1:0]          side,
   output logic                   out_valid,
   output logic [(XW+1)/2-1:0]    root,
   output logic [SW-1:0]          side_out
);
   localparam int RW  = (XW + 1) / 2;
   localparam int XPW = 2 * RW;
   localparam int RMW = RW + 1;

   logic [XPW-1:0] x_ff    [RW];
   logic [RMW-1:0] rem_ff  [RW];
   logic [RW-1:0]  root_ff [RW];
   logic [SW-1:0]  side_ff [RW];
   logic           valid_ff[RW];

   // one result bit per stage, two radicand bits consumed per stage
   for (genvar g = 0; g < RW; g++) begin : g_stage
      logic [XPW-1:0] x_cur;
      logic [RMW-1:0] rem_cur;
      logic [RW-1:0]  root_cur;
      logic [SW-1:0]  side_cur;
      logic           valid_cur;
      logic [RMW+1:0] rem_sh;
      logic [RMW+1:0] trial;
      logic [XPW-1:0] x_in;
      logic [RMW-1:0] rem_in;
      logic [RW-1:0]  root_in;

      if (g == 0) begin : g_head
         assign x_cur     = XPW'(x);
         assign rem_cur   = '0;
         assign root_cur  = '0;
         assign side_cur  = side;
         assign valid_cur = in_valid;
      end else begin : g_body
         assign x_cur     = x_ff[g-1];
         assign rem_cur   = rem_ff[g-1];
         assign root_cur  = root_ff[g-1];
         assign side_cur  = side_ff[g-1];
         assign valid_cur = valid_ff[g-1];
      end

      assign rem_sh = {rem_cur, x_cur[XPW-1 -: 2]};
      assign trial  = (RMW+2)'({root_cur, 2'b01});
      assign x_in   = {x_cur[XPW-3:0], 2'b00};

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in  = RMW'(rem_sh - trial);
            root_in = {root_cur[RW-2:0], 1'b1};
         end else begin
            rem_in  = RMW'(rem_sh);
            root_in = {root_cur[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[g]    <= x_in;
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            side_ff[g] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign root      = root_ff[RW-1];
   assign side_out  = side_ff[RW-1];

endmodule

// ===== design/rmq_div.sv =====
module rmq_div #(
   parameter int NMW       = 17,
   parameter int RW        = 16,
   parameter int FRAC_BITS = 14,
   parameter int SW        = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [NMW-1:0]         num [3],
   input  logic [RW-1:0]                 root,
   input  logic [SW-1:0]                 side,
   output logic                          out_valid,
   output logic [NMW+FRAC_BITS-1:0]      quo [3],
   output logic [SW-1:0]                 side_out
);
   localparam int NW = NMW + FRAC_BITS;
   localparam int DW = RW + 1;

   logic [NMW-1:0] mag [3];
   logic [NW-1:0]  dq_in [3];
   logic           pv_ff;
   logic [DW-1:0]  pden_ff;
   logic [NW-1:0]  pdq_ff [3];
   logic [SW-1:0]  pside_ff;

   logic [DW-1:0]  rem_ff  [NW][3];
   logic [NW-1:0]  dq_ff   [NW][3];
   logic [DW-1:0]  den_ff  [NW];
   logic [SW-1:0]  side_ff [NW];
   logic           valid_ff[NW];

   // dividend |n| * 2^F + root against divisor 2 * root rounds to nearest
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag[l]   = num[l][NMW-1] ? NMW'(-num[l]) : NMW'(num[l]);
         dq_in[l] = {mag[l], {FRAC_BITS{1'b0}}} + NW'(root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pden_ff  <= {root, 1'b0};
         pdq_ff   <= dq_in;
         pside_ff <= side;
      end
   end

   // restoring division, one quotient bit per stage, three lanes share the divisor
   for (genvar g = 0; g < NW; g++) begin : g_stage
      logic [DW-1:0] rem_cur [3];
      logic [NW-1:0] dq_cur  [3];
      logic [DW-1:0] den_cur;
      logic [SW-1:0] side_cur;
      logic          valid_cur;
      logic [DW:0]   rem_sh  [3];
      logic [DW-1:0] rem_in  [3];
      logic [NW-1:0] dq_in_g [3];

      if (g == 0) begin : g_head
         assign rem_cur   = '{default: '0};
         assign dq_cur    = pdq_ff;
         assign den_cur   = pden_ff;
         assign side_cur  = pside_ff;
         assign valid_cur = pv_ff;
      end else begin : g_body
         assign rem_cur   = rem_ff[g-1];
         assign dq_cur    = dq_ff[g-1];
         assign den_cur   = den_ff[g-1];
         assign side_cur  = side_ff[g-1];
         assign valid_cur = valid_ff[g-1];
      end

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            rem_sh[l] = {rem_cur[l], dq_cur[l][NW-1]};
            if (rem_sh[l] >= {1'b0, den_cur}) begin
               rem_in[l]  = DW'(rem_sh[l] - {1'b0, den_cur});
               dq_in_g[l] = {dq_cur[l][NW-2:0], 1'b1};
            end else begin
               rem_in[l]  = DW'(rem_sh[l]);
               dq_in_g[l] = {dq_cur[l][NW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            dq_ff[g]   <= dq_in_g;
            den_ff[g]  <= den_cur;
            side_ff[g] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign quo       = dq_ff[NW-1];
   assign side_out  = side_ff[NW-1];

endmodule

// ===== design/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion converter.
// req_chan carries one 3x3 rotation matrix per item (nine signed fixed-point
// elements with FRAC_BITS fraction bits); rsp_chan returns quat_x, quat_y,
// quat_z, quat_w in the same format plus a degenerate flag, set when the
// square-root term is zero or a component saturates.
// Both channels use valid/ready; an item moves when both are high.
// The pipeline is the front register, RW = (DATA_WIDTH+FRAC_BITS+3)/2
// square-root stages, the divider input register, NW = DATA_WIDTH+FRAC_BITS+1
// divider stages and the output register; default format Q2.14. One matrix is
// accepted every cycle while not stalled; the depth is set by the bit-per-stage
// square root and the three bit-per-stage dividers sharing one divisor.
// Reset clears every valid bit, so the pipeline comes up empty.
// When the receiver holds rsp_chan.ready low with a result waiting, the whole
// pipeline freezes and req_chan.ready drops; nothing is lost or repeated.
`include "assert_macros.svh"

module rotation_matrix_to_quaternion #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rmq_req_if.sink    req_chan,
   rmq_rsp_if.source  rsp_chan
);
   import rmq_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int NMW = W + 1;
   localparam int XW  = W + FRAC_BITS + 2;
   localparam int RW  = (XW + 1) / 2;
   localparam int NW  = NMW + FRAC_BITS;
   localparam int SW  = $bits(sel_type) + 3 * NMW + RW;
   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic [NW-1:0] LIM_POS = NW'(MAXV);
   localparam logic [NW-1:0] LIM_NEG = NW'(1) << (W - 1);

   logic                     pipe_en;
   logic                     fr_valid;
   sel_type                  fr_sel;
   logic [XW-1:0]            fr_x;
   logic signed [NMW-1:0]    fr_n0, fr_n1, fr_n2;
   logic                     sq_valid;
   logic [RW-1:0]            sq_root;
   logic [SW-1:0]            sq_side;
   sel_type                  sq_sel;
   logic signed [NMW-1:0]    sq_num [3];
   logic [RW-1:0]            sq_root_side;
   logic                     fin_valid;
   logic [NW-1:0]            fin_quo [3];
   logic [SW-1:0]            fin_side;
   sel_type                  fin_sel;
   logic signed [NMW-1:0]    fin_n0, fin_n1, fin_n2;
   logic signed [NMW-1:0]    fin_num [3];
   logic [RW-1:0]            fin_root;

   logic signed [W-1:0]      cv [3];
   logic [2:0]               lane_sat;
   logic [RW:0]              half_wide;
   logic signed [W-1:0]      half;
   logic                     half_sat;
   logic                     root_zero;
   logic signed [W-1:0]      qx_in, qy_in, qz_in, qw_in;
   logic                     deg_in;

   logic                     out_valid_ff;
   logic signed [W-1:0]      out_x_ff, out_y_ff, out_z_ff, out_w_ff;
   logic                     out_deg_ff;

   // advance everything unless a finished item is waiting on the receiver
   assign pipe_en        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = pipe_en;

   rmq_front #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (req_chan.valid),
      .r00      (req_chan.r00),
      .r10      (req_chan.r10),
      .r20      (req_chan.r20),
      .r01      (req_chan.r01),
      .r11      (req_chan.r11),
      .r21      (req_chan.r21),
      .r02      (req_chan.r02),
      .r12      (req_chan.r12),
      .r22      (req_chan.r22),
      .out_valid(fr_valid),
      .sel      (fr_sel),
      .x        (fr_x),
      .n0       (fr_n0),
      .n1       (fr_n1),
      .n2       (fr_n2)
   );

   rmq_sqrt #(
      .XW(XW),
      .SW(SW - RW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (fr_valid),
      .x        (fr_x),
      .side     ({fr_sel, fr_n0, fr_n1, fr_n2}),
      .out_valid(sq_valid),
      .root     (sq_root),
      .side_out (sq_side[SW-1:RW])
   );

   assign sq_side[RW-1:0] = sq_root;
   assign {sq_sel, sq_num[0], sq_num[1], sq_num[2], sq_root_side} = sq_side;

   rmq_div #(
      .NMW      (NMW),
      .RW       (RW),
      .FRAC_BITS(FRAC_BITS),
      .SW       (SW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (sq_valid),
      .num      (sq_num),
      .root     (sq_root_side),
      .side     (sq_side),
      .out_valid(fin_valid),
      .quo      (fin_quo),
      .side_out (fin_side)
   );

   assign {fin_sel, fin_n0, fin_n1, fin_n2, fin_root} = fin_side;
   assign fin_num[0] = fin_n0;
   assign fin_num[1] = fin_n1;
   assign fin_num[2] = fin_n2;
   assign root_zero  = (fin_root == '0);

   // sign, saturate, and place the components
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         lane_sat[l] = 1'b0;
         if (root_zero) begin
            if (fin_num[l] == '0) begin
               cv[l] = '0;
            end else if (fin_num[l][NMW-1]) begin
               cv[l]       = MINV;
               lane_sat[l] = 1'b1;
            end else begin
               cv[l]       = MAXV;
               lane_sat[l] = 1'b1;
            end
         end else if (fin_num[l][NMW-1]) begin
            if (fin_quo[l] > LIM_NEG) begin
               cv[l]       = MINV;
               lane_sat[l] = 1'b1;
            end else begin
               cv[l] = -W'(fin_quo[l]);
            end
         end else begin
            if (fin_quo[l] > LIM_POS) begin
               cv[l]       = MAXV;
               lane_sat[l] = 1'b1;
            end else begin
               cv[l] = W'(fin_quo[l]);
            end
         end
      end

      half_wide = ({1'b0, fin_root} + (RW+1)'(1)) >> 1;
      if (NW'(half_wide) > LIM_POS) begin
         half     = MAXV;
         half_sat = 1'b1;
      end else begin
         half     = W'(half_wide);
         half_sat = 1'b0;
      end

      qw_in = cv[2];
      case (fin_sel)
         SEL_X: begin
            qx_in = half;
            qy_in = cv[0];
            qz_in = cv[1];
         end
         SEL_Y: begin
            qx_in = cv[0];
            qy_in = half;
            qz_in = cv[1];
         end
         SEL_Z: begin
            qx_in = cv[0];
            qy_in = cv[1];
            qz_in = half;
         end
         default: begin
            qx_in = cv[0];
            qy_in = cv[1];
            qz_in = half;
         end
      endcase
      deg_in = root_zero || half_sat || (lane_sat != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         out_valid_ff <= fin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         out_x_ff   <= qx_in;
         out_y_ff   <= qy_in;
         out_z_ff   <= qz_in;
         out_w_ff   <= qw_in;
         out_deg_ff <= deg_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.quat_x     = out_x_ff;
   assign rsp_chan.quat_y     = out_y_ff;
   assign rsp_chan.quat_z     = out_z_ff;
   assign rsp_chan.quat_w     = out_w_ff;
   assign rsp_chan.degenerate = out_deg_ff;

   `RMQ_ASSERT_NEXT(a_zero_root_flags, clock, reset, pipe_en && fin_valid && root_zero, out_deg_ff, "zero root without degenerate flag")
   `RMQ_ASSERT_NEXT(a_item_reaches_out, clock, reset, pipe_en && fin_valid, out_valid_ff, "item lost at output register")
   `RMQ_ASSERT_NEXT(a_stall_freezes_div, clock, reset, !pipe_en, $stable(fin_valid), "divider moved during stall")
   `RMQ_ASSERT_IMPL(a_ready_follows_out, clock, reset, !req_chan.ready, out_valid_ff && !rsp_chan.ready, "input stalled without waiting item")

endmodule
